[rtl/arp_pkg.sv]
// Shared types, codes and constants of the atlas rectangle packer.
`default_nettype none
package arp_pkg;

    localparam int DefMaxSpaces  = 64;
    localparam int DefMaxEntries = 1024;
    localparam int DefCoordBits  = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_SPACES   = 3'd3;
    localparam logic [2:0] ST_ENTRIES  = 3'd4;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CLEAR  = 4'd2;
    localparam logic [3:0] OP_PASS   = 4'd3;
    localparam logic [3:0] OP_DIFF   = 4'd4;
    localparam logic [3:0] OP_FIT    = 4'd5;
    localparam logic [3:0] OP_MIN    = 4'd6;
    localparam logic [3:0] OP_GROW   = 4'd7;
    localparam logic [3:0] OP_APPEND = 4'd8;
    localparam logic [3:0] OP_COPY   = 4'd9;
    localparam logic [3:0] OP_PUSH0  = 4'd10;
    localparam logic [3:0] OP_PUSH1  = 4'd11;
    localparam logic [3:0] OP_PLACE  = 4'd12;

    typedef struct packed {
        logic        action;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] place_left;
        logic [15:0] place_top;
        logic [9:0]  entry_index;
        logic [15:0] handle_generation;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        logic       emit;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic       is_clear;
        logic       zero_size;
        logic       ent_full;
        logic       too_big;
        logic       cnt_zero;
        logic       idx_zero;
        logic       fit;
        logic       sp_over;
        logic       grow_sel;
        logic       grow_ovf;
        logic       cr_ovf;
        logic       list_full;
        logic [1:0] n;
    } t_sts;

endpackage
`default_nettype wire

[rtl/atlas_rect_packer_core.sv]
// Timing: a check state follows acceptance; a clear or a rejected item has its result
// strobe registered out of that check. An insert scans the free list with one registered
// memory read per entry (states RD, DIFF, FIT, MIN); a miss leads to a growth or append
// (states GRD, GEVAL), and the pass after it always fits. A fit goes on through PWAIT, the
// copy of the last space, up to two split pushes and placement before the strobe.
// One item at a time, busy drops in the strobe cycle; the receiver cannot stall. Synchronous
// reset empties the list, bounds and counters; the generation restarts at 0.
`default_nettype none
module atlas_rect_packer_core
    import arp_pkg::*;
#(
    parameter int MAX_SPACES  = DefMaxSpaces,
    parameter int MAX_ENTRIES = DefMaxEntries,
    parameter int COORD_BITS  = DefCoordBits
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  t_in       i_item,
    output t_out      o_result,
    output logic      o_done
);
    t_cmd cmd;
    t_sts sts;

    arp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    arp_dp #(
        .MAX_SPACES  (MAX_SPACES),
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_done   (o_done)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.place_left == '0 && o_result.entry_index == '0))
        else $error("failed item reports a placement");

endmodule
`default_nettype wire

[rtl/arp_ctrl.sv]
// Sequencer of the atlas packer: prechecks, scan passes, growth and placement.
`default_nettype none
module arp_ctrl
    import arp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_FIT   = 4'd4;
    localparam logic [3:0] S_MIN   = 4'd5;
    localparam logic [3:0] S_GRD   = 4'd6;
    localparam logic [3:0] S_GEVAL = 4'd7;
    localparam logic [3:0] S_PWAIT = 4'd8;
    localparam logic [3:0] S_PCP   = 4'd9;
    localparam logic [3:0] S_PW0   = 4'd10;
    localparam logic [3:0] S_PW1   = 4'd11;
    localparam logic [3:0] S_PDONE = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_pass, n_pass;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '{op: OP_NONE, emit: 1'b0, code: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                if (i_sts.is_clear) begin
                    o_cmd.op = OP_CLEAR;
                end else if (i_sts.zero_size) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_ZERO;
                end else if (i_sts.ent_full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_ENTRIES;
                end else if (i_sts.too_big) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_OVERFLOW;
                end else begin
                    o_cmd.op = OP_PASS;
                    n_pass   = 2'd0;
                    n_state  = i_sts.cnt_zero ? S_GRD : S_RD;
                end
            end
            S_RD:   n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_FIT;
            end
            S_FIT: begin
                o_cmd.op = OP_FIT;
                if (!i_sts.fit) begin
                    n_state = S_MIN;
                end else if (i_sts.sp_over) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_SPACES;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_PWAIT;
                end
            end
            S_MIN: begin
                o_cmd.op = OP_MIN;
                n_state  = i_sts.idx_zero ? S_GRD : S_RD;
            end
            S_GRD:  n_state = S_GEVAL;
            S_GEVAL: begin
                if (i_sts.grow_sel ? i_sts.grow_ovf : i_sts.cr_ovf) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_OVERFLOW;
                    n_state    = S_IDLE;
                end else if (!i_sts.grow_sel && i_sts.list_full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_SPACES;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = i_sts.grow_sel ? OP_GROW : OP_APPEND;
                    // A growth or append on the third pass still lands, then the item fails.
                    if (r_pass == 2'd2) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = ST_SPACES;
                        n_state    = S_IDLE;
                    end else begin
                        n_pass  = r_pass + 2'd1;
                        n_state = S_RD;
                    end
                end
            end
            S_PWAIT: n_state = S_PCP;
            S_PCP: begin
                o_cmd.op = OP_COPY;
                n_state  = (i_sts.n == 2'd0) ? S_PDONE : S_PW0;
            end
            S_PW0: begin
                o_cmd.op = OP_PUSH0;
                n_state  = (i_sts.n == 2'd2) ? S_PW1 : S_PDONE;
            end
            S_PW1: begin
                o_cmd.op = OP_PUSH1;
                n_state  = S_PDONE;
            end
            S_PDONE: begin
                o_cmd.op = OP_PLACE;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/arp_dp.sv]
// Datapath of the atlas packer: free space memory, scan registers, bounds and counters.
`default_nettype none
module arp_dp
    import arp_pkg::*;
#(
    parameter int MAX_SPACES  = DefMaxSpaces,
    parameter int MAX_ENTRIES = DefMaxEntries,
    parameter int COORD_BITS  = DefCoordBits
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_in       i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out      o_result,
    output logic      o_done
);
    localparam int CB = COORD_BITS;
    localparam int SW = CB + 2;
    localparam int PW = 2 * CB;
    localparam int AW = (MAX_SPACES > 1) ? $clog2(MAX_SPACES) : 1;
    localparam int NW = $clog2(MAX_SPACES + 1);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = 4 * CB;
    localparam logic [NW-1:0] MaxCnt = NW'(MAX_SPACES);
    localparam logic [EW-1:0] MaxEnt = EW'(MAX_ENTRIES);
    localparam logic [32:0]   Limit  = (33'd1 << CB) - 33'd1;

    logic [DW-1:0] mem [MAX_SPACES];
    logic [DW-1:0] r_rdata;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;

    logic [CB-1:0] r_w, r_h, r_bx, r_by;
    logic          r_act, r_big;
    // Raw zero test on the item as it came in, before narrowing to the coordinate width.
    logic          r_zero_in;
    logic [NW-1:0] r_cnt;
    logic [EW-1:0] r_ent;
    logic [15:0]   r_gen;
    logic [AW-1:0] r_idx, r_hit, r_best;
    logic          r_bv;
    logic [PW-1:0] r_area, r_barea;
    logic [CB-1:0] r_l, r_t, r_r, r_b, r_lw, r_th;
    logic signed [SW-1:0] r_cw, r_ch, r_fw, r_fh;
    logic [DW-1:0] r_p0, r_p1;
    logic [1:0]    r_n;
    t_out          r_out;
    logic          r_done;

    logic [CB-1:0] d_l, d_t, d_r, d_b;
    logic signed [SW-1:0] sw, sh, g_dw, g_dh;
    logic [CB:0]   g_lw, g_th, c_bw, c_bh;
    logic [1:0]    n_cnt;
    logic          fit;
    logic [AW-1:0] new_best;
    logic [CB-1:0] col_h, row_w;
    logic [15:0]   gen_inc;

    assign {d_l, d_t, d_r, d_b} = r_rdata;
    assign sw   = SW'(r_w);
    assign sh   = SW'(r_h);
    assign g_dw = sw - (SW'(d_r) - SW'(d_l));
    assign g_dh = sh - (SW'(d_b) - SW'(d_t));
    assign g_lw = {1'b0, d_l} + {1'b0, r_w};
    assign g_th = {1'b0, d_t} + {1'b0, r_h};
    assign c_bw = {1'b0, r_bx} + {1'b0, r_w};
    assign c_bh = {1'b0, r_by} + {1'b0, r_h};
    assign col_h = (r_by > r_h) ? r_by : r_h;
    assign row_w = (r_bx > r_w) ? r_bx : r_w;
    assign fit  = (r_fw >= 0) && (r_fh >= 0);
    assign n_cnt = ((r_fw > 0) && (r_fh > 0)) ? 2'd2 :
                   ((r_fw > 0) || (r_fh > 0)) ? 2'd1 : 2'd0;
    assign new_best = (!r_bv || (r_area < r_barea)) ? r_idx : r_best;
    assign gen_inc  = r_gen + 16'd1;

    always_comb begin
        o_sts.is_clear  = r_act;
        o_sts.zero_size = (r_w == '0 && !r_big) || (r_h == '0 && !r_big) || r_zero_in;
        o_sts.ent_full  = (r_ent >= MaxEnt);
        o_sts.too_big   = r_big;
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.idx_zero  = (r_idx == '0);
        o_sts.fit       = fit;
        o_sts.sp_over   = (32'(r_cnt) + 32'(n_cnt)) > (32'(MAX_SPACES) + 32'd1);
        o_sts.grow_sel  = r_bv && (g_dw < sh) && (g_dh < sw);
        o_sts.grow_ovf  = g_lw[CB] || g_th[CB];
        o_sts.cr_ovf    = (r_bx <= r_by) ? c_bw[CB] : c_bh[CB];
        o_sts.list_full = (r_cnt >= MaxCnt);
        o_sts.n         = r_n;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_rdata;
        case (i_cmd.op)
            OP_GROW: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = {d_l, d_t, g_lw[CB-1:0], g_th[CB-1:0]};
            end
            OP_APPEND: begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = (r_bx <= r_by) ? {r_bx, CB'(0), c_bw[CB-1:0], col_h}
                                       : {CB'(0), r_by, row_w, c_bh[CB-1:0]};
            end
            OP_COPY: begin
                we    = 1'b1;
                waddr = r_hit;
                wdata = r_rdata;
            end
            OP_PUSH0: begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = r_p0;
            end
            OP_PUSH1: begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = r_p1;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bx   <= '0;
            r_by   <= '0;
            r_ent  <= '0;
            r_gen  <= '0;
            r_done <= 1'b0;
            r_bv   <= 1'b0;
        end else begin
            r_done <= i_cmd.emit || (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_PLACE);
            if (i_cmd.emit) begin
                r_out  <= '{status: i_cmd.code, place_left: '0, place_top: '0,
                            entry_index: '0, handle_generation: r_gen};
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_act     <= i_item.action;
                    r_w       <= CB'(i_item.rect_width);
                    r_h       <= CB'(i_item.rect_height);
                    r_zero_in <= (i_item.rect_width == '0) || (i_item.rect_height == '0);
                    r_big     <= (33'(i_item.rect_width) > Limit)
                              || (33'(i_item.rect_height) > Limit);
                end
                OP_CLEAR: begin
                    r_cnt  <= '0;
                    r_bx   <= '0;
                    r_by   <= '0;
                    r_ent  <= '0;
                    r_gen  <= (gen_inc == '0) ? 16'd1 : gen_inc;
                    r_out  <= '{status: ST_OK, place_left: '0, place_top: '0,
                                entry_index: '0,
                                handle_generation: (gen_inc == '0) ? 16'd1 : gen_inc};
                end
                OP_PASS: begin
                    r_idx <= AW'(r_cnt - NW'(1));
                    r_bv  <= 1'b0;
                end
                OP_DIFF: begin
                    r_l  <= d_l;
                    r_t  <= d_t;
                    r_r  <= d_r;
                    r_b  <= d_b;
                    r_lw <= CB'(g_lw);
                    r_th <= CB'(g_th);
                    r_cw <= SW'(d_r) - SW'(d_l);
                    r_ch <= SW'(d_b) - SW'(d_t);
                    r_fw <= SW'(d_r) - SW'(d_l) - sw;
                    r_fh <= SW'(d_b) - SW'(d_t) - sh;
                end
                OP_FIT: begin
                    r_area <= PW'(r_cw[CB-1:0]) * PW'(r_ch[CB-1:0]);
                    r_n    <= n_cnt;
                    if ((r_fw > 0) && (r_fh > 0)) begin
                        if (r_fw > r_fh) begin
                            r_p0 <= {r_lw, r_t, r_r, r_b};
                            r_p1 <= {r_l, r_th, r_lw, r_b};
                        end else begin
                            r_p0 <= {r_l, r_th, r_r, r_b};
                            r_p1 <= {r_lw, r_t, r_r, r_th};
                        end
                    end else if (r_fw > 0) begin
                        r_p0 <= {r_lw, r_t, r_r, r_b};
                        r_p1 <= {r_lw, r_t, r_r, r_b};
                    end else begin
                        r_p0 <= {r_l, r_th, r_r, r_b};
                        r_p1 <= {r_l, r_th, r_r, r_b};
                    end
                    if (fit) begin
                        r_hit <= r_idx;
                        r_idx <= AW'(r_cnt - NW'(1));
                    end
                end
                OP_MIN: begin
                    r_bv   <= 1'b1;
                    r_best <= new_best;
                    if (!r_bv || (r_area < r_barea)) begin
                        r_barea <= r_area;
                    end
                    r_idx <= (r_idx == '0) ? new_best : r_idx - AW'(1);
                end
                OP_GROW: begin
                    r_idx <= AW'(r_cnt - NW'(1));
                    r_bv  <= 1'b0;
                end
                OP_APPEND: begin
                    r_cnt <= r_cnt + NW'(1);
                    r_idx <= r_cnt[AW-1:0];
                    r_bv  <= 1'b0;
                end
                OP_COPY:  r_cnt <= r_cnt - NW'(1);
                OP_PUSH0: r_cnt <= r_cnt + NW'(1);
                OP_PUSH1: r_cnt <= r_cnt + NW'(1);
                OP_PLACE: begin
                    if (r_lw > r_bx) begin
                        r_bx <= r_lw;
                    end
                    if (r_th > r_by) begin
                        r_by <= r_th;
                    end
                    r_ent  <= r_ent + EW'(1);
                    r_out  <= '{status: ST_OK, place_left: 16'(r_l), place_top: 16'(r_t),
                                entry_index: 10'(r_ent), handle_generation: r_gen};
                end
                default: ;
            endcase
        end
    end

    assign o_result = r_out;
    assign o_done   = r_done;

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the atlas rectangle packer core.
module testbench;
    import arp_pkg::*;

    localparam int      NumSpaces  = 64;
    localparam int      NumEntries = 1024;
    localparam longint  CoordMax   = 65535;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    t_out o_result;
    logic o_done;

    atlas_rect_packer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_result(o_result),
        .o_done  (o_done)
    );

    // Local copy of the packer state.
    longint   sp_l [NumSpaces];
    longint   sp_t [NumSpaces];
    longint   sp_r [NumSpaces];
    longint   sp_b [NumSpaces];
    int       free_count;
    longint   atlas_w;
    longint   atlas_h;
    int       placed_count;
    int       generation;

    t_out     pending_results[$];
    int       err_count;
    int       items_sent;
    int       status_seen [5];
    bit       quiet_sender;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void push_space(longint l, longint t, longint r, longint b);
        sp_l[free_count] = l;
        sp_t[free_count] = t;
        sp_r[free_count] = r;
        sp_b[free_count] = b;
        free_count++;
    endfunction

    // Guillotine placement with in-place growth or a new column or row on a miss.
    function automatic logic [2:0] pack_rect(longint w, longint h,
                                             output longint pl, output longint pt);
        int     best;
        longint best_area;
        longint cl, ct, cr, cb, cw, ch, fw, fh, area;
        longint nl [2];
        longint nt [2];
        longint nr [2];
        longint nb [2];
        int     n;
        int     last;
        pl = 0;
        pt = 0;
        for (int pass = 0; pass < 3; pass++) begin
            best = -1;
            best_area = 0;
            for (int i = free_count - 1; i >= 0; i--) begin
                cl = sp_l[i]; ct = sp_t[i]; cr = sp_r[i]; cb = sp_b[i];
                cw = cr - cl;
                ch = cb - ct;
                fw = cw - w;
                fh = ch - h;
                area = cw * ch;
                if (best < 0 || area < best_area) begin
                    best = i;
                    best_area = area;
                end
                if (fw < 0 || fh < 0) continue;
                n = 0;
                if (fw > 0 && fh == 0) begin
                    nl[0] = cl + w; nt[0] = ct; nr[0] = cr; nb[0] = cb; n = 1;
                end else if (fw == 0 && fh > 0) begin
                    nl[0] = cl; nt[0] = ct + h; nr[0] = cr; nb[0] = cb; n = 1;
                end else if (fw > 0 && fh > 0) begin
                    if (fw > fh) begin
                        nl[0] = cl + w; nt[0] = ct;     nr[0] = cr;     nb[0] = cb;
                        nl[1] = cl;     nt[1] = ct + h; nr[1] = cl + w; nb[1] = cb;
                    end else begin
                        nl[0] = cl;     nt[0] = ct + h; nr[0] = cr;     nb[0] = cb;
                        nl[1] = cl + w; nt[1] = ct;     nr[1] = cr;     nb[1] = ct + h;
                    end
                    n = 2;
                end
                if (free_count - 1 + n > NumSpaces) return ST_SPACES;
                last = free_count - 1;
                sp_l[i] = sp_l[last]; sp_t[i] = sp_t[last];
                sp_r[i] = sp_r[last]; sp_b[i] = sp_b[last];
                free_count--;
                for (int k = 0; k < n; k++) push_space(nl[k], nt[k], nr[k], nb[k]);
                if (cl + w > atlas_w) atlas_w = cl + w;
                if (ct + h > atlas_h) atlas_h = ct + h;
                pl = cl;
                pt = ct;
                return ST_OK;
            end
            if (best >= 0 && (w - (sp_r[best] - sp_l[best])) < h &&
                (h - (sp_b[best] - sp_t[best])) < w) begin
                if (sp_l[best] + w > CoordMax || sp_t[best] + h > CoordMax)
                    return ST_OVERFLOW;
                sp_r[best] = sp_l[best] + w;
                sp_b[best] = sp_t[best] + h;
            end else if (atlas_w <= atlas_h) begin
                if (w > CoordMax - atlas_w) return ST_OVERFLOW;
                if (free_count >= NumSpaces) return ST_SPACES;
                push_space(atlas_w, 0, atlas_w + w, (atlas_h > h) ? atlas_h : h);
            end else begin
                if (h > CoordMax - atlas_h) return ST_OVERFLOW;
                if (free_count >= NumSpaces) return ST_SPACES;
                push_space(0, atlas_h, (atlas_w > w) ? atlas_w : w, atlas_h + h);
            end
        end
        return ST_SPACES;
    endfunction

    function automatic t_out predict_result(t_in item);
        t_out   res;
        longint pl, pt;
        logic [2:0] code;
        res = '0;
        if (item.action) begin
            free_count = 0;
            atlas_w = 0;
            atlas_h = 0;
            placed_count = 0;
            generation = (generation + 1) & 16'hFFFF;
            if (generation == 0) generation = 1;
        end else if (item.rect_width == 0 || item.rect_height == 0) begin
            res.status = ST_ZERO;
        end else if (placed_count >= NumEntries) begin
            res.status = ST_ENTRIES;
        end else begin
            code = pack_rect(longint'(item.rect_width), longint'(item.rect_height), pl, pt);
            res.status = code;
            if (code == ST_OK) begin
                res.place_left  = pl[15:0];
                res.place_top   = pt[15:0];
                res.entry_index = placed_count[9:0];
                placed_count++;
            end
        end
        res.handle_generation = generation[15:0];
        return res;
    endfunction

    // Drives one item from a falling edge and holds it until the block takes it.
    task automatic send_item(logic act, logic [15:0] w, logic [15:0] h);
        t_out exp_item;
        @(negedge i_clk);
        if (!quiet_sender && $urandom_range(99) < 9) begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        i_item = '{action: act, rect_width: w, rect_height: h};
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        exp_item = predict_result(i_item);
        pending_results = {pending_results, exp_item};
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no item outstanding");
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result.status <= ST_ENTRIES) status_seen[o_result.status]++;
                if (o_result.status !== exp_res.status) begin
                    $error("status exp %0d got %0d", exp_res.status, o_result.status);
                    err_count++;
                end
                if (o_result.place_left !== exp_res.place_left) begin
                    $error("place_left exp %0d got %0d", exp_res.place_left,
                           o_result.place_left);
                    err_count++;
                end
                if (o_result.place_top !== exp_res.place_top) begin
                    $error("place_top exp %0d got %0d", exp_res.place_top,
                           o_result.place_top);
                    err_count++;
                end
                if (o_result.entry_index !== exp_res.entry_index) begin
                    $error("entry_index exp %0d got %0d", exp_res.entry_index,
                           o_result.entry_index);
                    err_count++;
                end
                if (o_result.handle_generation !== exp_res.handle_generation) begin
                    $error("handle_generation exp %0d got %0d",
                           exp_res.handle_generation, o_result.handle_generation);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // Inserts before any clear report generation zero.
        send_item(1'b0, 16'd10, 16'd20);
        send_item(1'b0, 16'd0, 16'd5);
        send_item(1'b0, 16'd5, 16'd0);
        send_item(1'b0, 16'd0, 16'd0);
        send_item(1'b1, 16'd0, 16'd0);
        send_item(1'b0, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 16'd1, 16'd1);
        send_item(1'b1, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 16'hFFFF, 16'd1);
        send_item(1'b0, 16'd1, 16'hFFFF);
        send_item(1'b0, 16'h8000, 16'h8000);
        send_item(1'b1, 16'd0, 16'd0);
        send_item(1'b0, 16'd30, 16'd10);
        send_item(1'b0, 16'd10, 16'd30);
        send_item(1'b0, 16'd5, 16'd5);
        send_item(1'b0, 16'd30, 16'd30);
        send_item(1'b0, 16'd3, 16'd7);
        send_item(1'b0, 16'd40000, 16'd2);
        send_item(1'b0, 16'd40000, 16'd2);
        send_item(1'b0, 16'd2, 16'd40000);
        send_item(1'b0, 16'd2, 16'd40000);
        send_item(1'b0, 16'd1, 16'd1);
    endtask

    // Small rectangles until the entry count runs out, then a few refused inserts.
    task automatic test_entry_limit();
        int guard;
        guard = 0;
        send_item(1'b1, 16'd0, 16'd0);
        while (placed_count < NumEntries && guard < 1060) begin
            send_item(1'b0, 16'($urandom_range(2, 1)), 16'($urandom_range(2, 1)));
            guard++;
        end
        send_item(1'b0, 16'd1, 16'd1);
        send_item(1'b0, 16'd0, 16'd1);
        send_item(1'b1, 16'd0, 16'd0);
    endtask

    // After one clear, many uneven sizes with no further clear so the free list fills up.
    task automatic test_space_limit();
        send_item(1'b1, 16'd0, 16'd0);
        for (int i = 0; i < 100; i++)
            send_item(1'b0, 16'($urandom_range(97, 2)), 16'($urandom_range(97, 2)));
    endtask

    task automatic test_random(int count);
        int sel;
        logic [15:0] w, h;
        for (int i = 0; i < count; i++) begin
            quiet_sender = (i >= 40 && i < 100);
            if (i == 110) wait_drained();
            sel = $urandom_range(99);
            w = 16'($urandom_range(64, 1));
            h = 16'($urandom_range(64, 1));
            if (sel < 3) begin
                send_item(1'b1, 16'($urandom), 16'($urandom));
                continue;
            end
            if (sel < 6) w = 16'd0;
            else if (sel < 8) h = 16'd0;
            else if (sel < 14) w = 16'($urandom);
            else if (sel < 20) h = 16'($urandom);
            else if (sel < 22) begin
                w = 16'hFFFF;
                h = 16'($urandom);
            end else if (sel < 30) begin
                w = 16'($urandom_range(1000, 1));
                h = 16'($urandom_range(1000, 1));
            end
            send_item(1'b0, w, h);
        end
        quiet_sender = 1'b0;
    endtask

    initial begin
        int tail;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        err_count = 0;
        items_sent = 0;
        quiet_sender = 1'b0;
        free_count = 0;
        atlas_w = 0;
        atlas_h = 0;
        placed_count = 0;
        generation = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_entry_limit();
        test_space_limit();
        test_random(150);

        wait_drained();
        tail = 0;
        while (tail < 40) begin
            @(posedge i_clk);
            tail++;
        end
        $display("Sent %0d items; ok %0d, zero size %0d, overflow %0d,", items_sent,
                 status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_OVERFLOW]);
        $display("spaces full %0d, entries full %0d, mismatches %0d.",
                 status_seen[ST_SPACES], status_seen[ST_ENTRIES], err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
rtl/arp_pkg.sv
rtl/arp_ctrl.sv
rtl/arp_dp.sv
rtl/atlas_rect_packer_core.sv
verif/testbench.sv
